/* rtl/rtu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rtu_pkg
// Shared types and constants for the rank transform unit.
// ---------------------------------------------------------------------------
package rtu_pkg;

  localparam int DEPTH      = 64;
  localparam int VAL_W      = 32;
  localparam int OUT_RANK_W = 6;
  localparam int RANK_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CYC_W      = RANK_W;

  typedef enum logic [1:0] {
    PH_LOAD,
    PH_RANK,
    PH_EMIT
  } rtu_phase_t;

  // control broadcast to every cell
  typedef struct packed {
    logic shift;
    logic rotate;
    logic clear;
  } rtu_ctl_t;

  // stored word moving along the chain
  typedef struct packed {
    logic                     vld;
    logic signed [VAL_W-1:0]  val;
    logic        [RANK_W-1:0] rank;
  } rtu_word_t;

  // circulating probe
  typedef struct packed {
    logic                    vld;
    logic signed [VAL_W-1:0] val;
  } rtu_probe_t;

endpackage

`default_nettype wire

/* rtl/rtu_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rtu_cell
// One chain cell: holds a stored word and its rank count, and compares the
// probe passing through against its own value once per rotation step.
// ---------------------------------------------------------------------------
module rtu_cell (
  input  wire                 clk,
  input  wire                 rst_n,
  input  rtu_pkg::rtu_ctl_t   ctl,
  input  rtu_pkg::rtu_word_t  word_in,
  output rtu_pkg::rtu_word_t  word_out,
  input  rtu_pkg::rtu_probe_t probe_in,
  output rtu_pkg::rtu_probe_t probe_out
);
  import rtu_pkg::*;

  logic                    vld_r;
  logic signed [VAL_W-1:0] val_r;
  logic [RANK_W-1:0]       rank_r;
  logic                    pvld_r;
  logic signed [VAL_W-1:0] pval_r;
  logic                    hit;

  assign hit = pvld_r && vld_r && (pval_r < val_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      pvld_r <= 1'b0;
    end else if (ctl.clear) begin
      vld_r  <= 1'b0;
      pvld_r <= 1'b0;
    end else if (ctl.shift) begin
      vld_r  <= word_in.vld;
      pvld_r <= word_in.vld;
    end else if (ctl.rotate) begin
      pvld_r <= probe_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      val_r  <= word_in.val;
      rank_r <= word_in.rank;
      pval_r <= word_in.val;
    end else if (ctl.rotate) begin
      pval_r <= probe_in.val;
      if (hit) begin
        rank_r <= rank_r + 1'b1;
      end
    end
  end

  assign word_out.vld  = vld_r;
  assign word_out.val  = val_r;
  assign word_out.rank = rank_r;
  assign probe_out.vld = pvld_r;
  assign probe_out.val = pval_r;

endmodule

`default_nettype wire

/* rtl/rtu_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rtu_ctrl
// Phase sequencer: load, rank rotation and drain of the cell chain.
// ---------------------------------------------------------------------------
module rtu_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire               in_last_value,
  input  wire               out_stall,
  input  wire               head_vld,
  output rtu_pkg::rtu_ctl_t ctl,
  output logic              tail_vld,
  output logic              in_stall,
  output logic              out_valid,
  output logic              out_last_rank,
  output logic              out_overflow
);
  import rtu_pkg::*;

  rtu_phase_t       phase_r, phase_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CYC_W-1:0] cyc_r, cyc_nxt;
  logic             dropped_r, dropped_nxt;
  logic             in_acc, out_acc, full, store;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign in_acc  = (phase_r == PH_LOAD) && in_valid;
  assign store   = in_acc && !full;
  assign out_acc = out_valid && !out_stall;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_LOAD: if (in_acc && in_last_value) phase_nxt = PH_RANK;
      PH_RANK: if (cyc_r == CYC_W'(DEPTH - 1)) phase_nxt = PH_EMIT;
      PH_EMIT: if (out_acc && count_r == CNT_W'(1)) phase_nxt = PH_LOAD;
      default: phase_nxt = PH_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    tail_vld      = 1'b0;
    ctl.shift     = 1'b0;
    ctl.rotate    = 1'b0;
    ctl.clear     = 1'b0;
    case (phase_r)
      PH_LOAD: begin
        in_stall  = 1'b0;
        tail_vld  = 1'b1;
        ctl.shift = store;
      end
      PH_RANK: begin
        ctl.rotate = 1'b1;
      end
      PH_EMIT: begin
        out_valid = head_vld;
        // empty head slots are skipped without a word
        ctl.shift = !head_vld || !out_stall;
        ctl.clear = out_acc && (count_r == CNT_W'(1));
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign out_last_rank = (count_r == CNT_W'(1));
  assign out_overflow  = dropped_r;

  always_comb begin
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    cyc_nxt     = '0;
    if (store) begin
      count_nxt = count_r + 1'b1;
    end
    if (in_acc && full) begin
      dropped_nxt = 1'b1;
    end
    if (phase_r == PH_RANK) begin
      cyc_nxt = cyc_r + 1'b1;
    end
    if (out_acc) begin
      count_nxt = count_r - 1'b1;
    end
    if (ctl.clear) begin
      dropped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LOAD;
      count_r   <= '0;
      cyc_r     <= '0;
      dropped_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      count_r   <= count_nxt;
      cyc_r     <= cyc_nxt;
      dropped_r <= dropped_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/rank_transform_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rank_transform_unit
// Ranks a loaded set of signed values: each result is the count of stored
// values strictly less than the element, given in arrival order.
//
//   channel  dir  handshake           word
//   in_      in   in_valid/in_stall   in_value, in_last_value
//   out_     out  out_valid/out_stall out_rank, out_last_rank, out_overflow
//
// Load: one word per cycle into the cell chain until the last-marked word.
// Rank: one probe rotation step per cycle around the ring.
// Drain: the DEPTH - n empty head slots ahead of an n-word set are skipped
// first, then one rank per cycle while out_stall is low.
// Synchronous active-low reset empties the set; out_stall holds the head word.
// ---------------------------------------------------------------------------
module rank_transform_unit (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire signed [rtu_pkg::VAL_W-1:0] in_value,
  input  wire                             in_last_value,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [rtu_pkg::OUT_RANK_W-1:0]  out_rank,
  output logic                            out_last_rank,
  output logic                            out_overflow
);
  import rtu_pkg::*;

  rtu_ctl_t   ctl;
  logic       tail_vld;
  rtu_word_t  words [DEPTH];
  rtu_probe_t probes [DEPTH];
  rtu_word_t  tail_word;

  assign tail_word.vld  = tail_vld;
  assign tail_word.val  = in_value;
  assign tail_word.rank = '0;

  rtu_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_last_value (in_last_value),
    .out_stall     (out_stall),
    .head_vld      (words[0].vld),
    .ctl           (ctl),
    .tail_vld      (tail_vld),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_last_rank (out_last_rank),
    .out_overflow  (out_overflow)
  );

  // words move toward cell 0; probes ring around with cell 0 feeding the tail
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k == DEPTH - 1) begin : g_tail
      rtu_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .word_in   (tail_word),
        .word_out  (words[k]),
        .probe_in  (probes[0]),
        .probe_out (probes[k])
      );
    end else begin : g_body
      rtu_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .word_in   (words[k+1]),
        .word_out  (words[k]),
        .probe_in  (probes[k+1]),
        .probe_out (probes[k])
      );
    end
  end

  assign out_rank = OUT_RANK_W'(words[0].rank);

`ifndef SYNTHESIS
  a_no_load_while_draining: assert property (
    @(posedge clk) disable iff (!rst_n) out_valid |-> in_stall
  ) else $error("word offered while input side open");

  a_last_closes_input: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_value) |=> in_stall
  ) else $error("input still open after last word");

  a_reopen_after_last: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_rank) |=> (!in_stall && !out_valid)
  ) else $error("set not closed after final rank");
`endif

endmodule

`default_nettype wire

/* verif/tb_rank_transform_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rank_transform_unit
// Self-checking bench for the rank transform unit. Sets of signed words are
// loaded with random sender gaps; a scoreboard ranks each finished set and
// checks every result word, in order, against the block's output while the
// receiver stalls at random.
// ---------------------------------------------------------------------------
module tb_rank_transform_unit;

  localparam int VAL_W       = rtu_pkg::VAL_W;
  localparam int RANK_OUT_W  = rtu_pkg::OUT_RANK_W;
  localparam int SET_DEPTH   = rtu_pkg::DEPTH;
  localparam int ITEM_TARGET = 130;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int MAX_PRINTS  = 40;

  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  typedef struct packed {
    logic [RANK_OUT_W-1:0] rank;
    logic                  last_rank;
    logic                  overflow;
  } rank_word_t;

  // Tracks the set being loaded and the rank words still owed by the block.
  class rank_scoreboard;
    logic signed [VAL_W-1:0] set_vals[$];
    bit                      dropped;
    rank_word_t              ranks_due[$];
    int                      errors;

    task report(string what, int got, int want);
      if (errors < MAX_PRINTS)
        $display("ERROR @%0t: %s got %0d want %0d", $realtime, what, got, want);
      errors++;
    endtask

    function int pending();
      return ranks_due.size();
    endfunction

    function void note_input(logic signed [VAL_W-1:0] v, logic is_last);
      int unsigned smaller;
      rank_word_t  w;
      if (set_vals.size() < SET_DEPTH) set_vals.push_back(v);
      else dropped = 1'b1;
      if (!is_last) return;
      foreach (set_vals[i]) begin
        smaller = 0;
        foreach (set_vals[j]) if (set_vals[j] < set_vals[i]) smaller++;
        w.rank      = smaller[RANK_OUT_W-1:0];
        w.last_rank = (i == set_vals.size() - 1);
        w.overflow  = dropped;
        ranks_due.push_back(w);
      end
      set_vals.delete();
      dropped = 1'b0;
    endfunction

    task check_result(logic [RANK_OUT_W-1:0] rank, logic last_rank,
                      logic overflow);
      rank_word_t w;
      if (ranks_due.size() == 0) begin
        report("unexpected word, rank", rank, -1);
        return;
      end
      w = ranks_due.pop_front();
      if (rank !== w.rank) report("rank", rank, w.rank);
      if (last_rank !== w.last_rank) report("last_rank", last_rank, w.last_rank);
      if (overflow !== w.overflow) report("overflow", overflow, w.overflow);
    endtask
  endclass

  logic                          clk           = 1'b0;
  logic                          rst_n         = 1'b0;
  logic                          in_valid      = 1'b0;
  logic                          in_stall;
  logic signed [VAL_W-1:0]       in_value      = '0;
  logic                          in_last_value = 1'b0;
  logic                          out_valid;
  logic                          out_stall     = 1'b0;
  logic [RANK_OUT_W-1:0]         out_rank;
  logic                          out_last_rank;
  logic                          out_overflow;

  rank_scoreboard                sb = new;
  int                            words_sent;
  int                            cycle_count;
  bit                            send_burst;
  bit                            drain_quiet;
  logic signed [VAL_W-1:0]       word_list[$];

  rank_transform_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .in_last_value (in_last_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_rank      (out_rank),
    .out_last_rank (out_last_rank),
    .out_overflow  (out_overflow)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL rank_transform_unit");
      $finish;
    end
  end

  // valid only drops when a gap is drawn, so a back-to-back word never
  // sees a low/high pair in one step
  task automatic send_word(input logic signed [VAL_W-1:0] v, input logic is_last);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_value      <= v;
    in_last_value <= is_last;
    do @(posedge clk); while (in_stall);
    sb.note_input(v, is_last);
    words_sent++;
  endtask

  task automatic send_list();
    foreach (word_list[k]) send_word(word_list[k], k == word_list.size() - 1);
    word_list.delete();
  endtask

  // mix of full-range words, tie-prone small words and extremes
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $signed($urandom_range(0, 6)) - 3;
      1: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // receiver: a fresh stall length is drawn after every accepted word
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_result(out_rank, out_last_rank, out_overflow);
        if ($urandom_range(0, 15) == 0) drain_quiet = !drain_quiet;
        hold = drain_quiet ? 0 : $urandom_range(0, 19);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int set_no;
    int set_size;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed sets: single word, extremes with ties, all equal, descending, and a tie around a large word
    send_burst = 1'b1;
    word_list = '{VAL_MAX};
    send_list();
    send_burst = 1'b0;
    word_list = '{VAL_MIN, VAL_MAX, 0, -1, 1, VAL_MIN, VAL_MAX};
    send_list();
    word_list = '{5, 5, 5, 5};
    send_list();
    send_burst = 1'b1;
    word_list = '{3, 2, 1, 0, -1};
    send_list();
    send_burst = 1'b0;
    word_list = '{-2, 40000, -2};
    send_list();

    // random sets; set 1 overruns the store, set 4 fills it exactly
    set_no = 0;
    while (words_sent < ITEM_TARGET || set_no < 6) begin
      case (set_no)
        1:       set_size = SET_DEPTH + $urandom_range(1, 4);
        4:       set_size = SET_DEPTH;
        default: set_size = $urandom_range(1, 10);
      endcase
      send_burst = ($urandom_range(0, 3) == 0);
      if (set_no == 3) begin
        // hold off until the block has drained everything
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      for (int k = 0; k < set_size; k++) send_word(pick_value(), k == set_size - 1);
      set_no++;
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4 * SET_DEPTH) @(posedge clk);
    if (sb.errors == 0) $display("PASS rank_transform_unit");
    else $display("FAIL rank_transform_unit");
    $finish;
  end

endmodule

/* sim.f */
rtl/rtu_pkg.sv
rtl/rtu_cell.sv
rtl/rtu_ctrl.sv
rtl/rank_transform_unit.sv
verif/tb_rank_transform_unit.sv
